// ===== sv/smhd_pkg.sv =====
// ----------------------------------------------------------------------------
// smhd_pkg: shared types and constants for the sprite mask hit detector
// Field widths, status codes, register indexes and the stage flag struct.
// ----------------------------------------------------------------------------
package smhd_pkg;

	// Fixed field widths
	localparam int FIELD_W     = 64;
	localparam int NUM_MASKS   = 6;
	localparam int IN_TDATA_W  = FIELD_W * NUM_MASKS;
	localparam int DIST_W      = 7;
	localparam int ROW_W       = 6;
	localparam int ZERO_W      = 6;
	localparam int ROW_SUM_W   = ROW_W + 1;
	localparam int OUT_TDATA_W = 24;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = DIST_W;

	// Default mask width and number of sheet rows for the row wrap
	localparam int MASK_BITS_DEF = 64;
	localparam int SHEET_ROWS    = 64;

	// Per-sprite outcome
	typedef enum logic [1:0] {
		STAT_NONE    = 2'd0,
		STAT_HIT     = 2'd1,
		STAT_BLOCKED = 2'd2
	} status_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHIFT_DISTANCE = 2'd0,
		REG_FIRST_IS_RIGHT = 2'd1,
		REG_FIRST_ROW      = 2'd2
	} reg_idx_t;

	// Configuration register contents
	typedef struct packed {
		logic [DIST_W-1:0] shift_distance;
		logic              first_is_right;
		logic [ROW_W-1:0]  first_row;
	} cfg_t;

	// Per-row flags carried alongside the hit masks
	typedef struct packed {
		logic any_a;
		logic any_b;
		logic blk_a;
		logic blk_b;
		logic last;
	} row_flags_t;

endpackage

// ===== sv/smhd_cfg.sv =====
// ----------------------------------------------------------------------------
// smhd_cfg: configuration register file
// Holds shift distance, side select and first window row; writes to unknown
// indexes are dropped.
// ----------------------------------------------------------------------------
module smhd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [smhd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smhd_pkg::CFG_DATA_W-1:0] cfg_data,
	output smhd_pkg::cfg_t                  cfg
);
	import smhd_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shift_distance <= '0;
			cfg_q.first_is_right <= 1'b1;
			cfg_q.first_row      <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SHIFT_DISTANCE: cfg_q.shift_distance <= cfg_data[DIST_W-1:0];
				REG_FIRST_IS_RIGHT: cfg_q.first_is_right <= cfg_data[0];
				REG_FIRST_ROW:      cfg_q.first_row      <= cfg_data[ROW_W-1:0];
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/smhd_align.sv =====
// ----------------------------------------------------------------------------
// smhd_align: input register and mask alignment stage
// Registers a row of six masks, aligns attack against body and guard masks
// by the configured shift and registers the hit masks and flags.
// ----------------------------------------------------------------------------
module smhd_align #(
	parameter int MASK_BITS = smhd_pkg::MASK_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  smhd_pkg::cfg_t                  cfg,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [smhd_pkg::IN_TDATA_W-1:0] s_tdata,
	input  logic                            s_tlast,
	input  logic                            go_s2,
	output logic                            valid_s2,
	output logic [MASK_BITS-1:0]            hit_a_s2,
	output logic [MASK_BITS-1:0]            hit_b_s2,
	output smhd_pkg::row_flags_t            flags_s2
);
	import smhd_pkg::*;

	logic                 valid_s1;
	logic [MASK_BITS-1:0] body_a_s1, attack_a_s1, guard_a_s1;
	logic [MASK_BITS-1:0] body_b_s1, attack_b_s1, guard_b_s1;
	logic                 last_s1;
	logic                 load_s1, load_s2;
	logic                 in_range;
	logic [MASK_BITS-1:0] hit_a, hit_b, blk_a_m, blk_b_m;
	logic [DIST_W-1:0]    d;

	// Flow control: s1 moves on when s2 is empty or being drained
	assign load_s2  = valid_s1 && (!valid_s2 || go_s2);
	assign s_tready = !valid_s1 || load_s2;
	assign load_s1  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (load_s2)
				valid_s2 <= 1'b1;
			else if (go_s2)
				valid_s2 <= 1'b0;
		end
	end

	// Capture the row, keeping only the active mask bits
	always_ff @(posedge clk) begin
		if (load_s1) begin
			body_a_s1   <= s_tdata[0*FIELD_W +: MASK_BITS];
			attack_a_s1 <= s_tdata[1*FIELD_W +: MASK_BITS];
			guard_a_s1  <= s_tdata[2*FIELD_W +: MASK_BITS];
			body_b_s1   <= s_tdata[3*FIELD_W +: MASK_BITS];
			attack_b_s1 <= s_tdata[4*FIELD_W +: MASK_BITS];
			guard_b_s1  <= s_tdata[5*FIELD_W +: MASK_BITS];
			last_s1     <= s_tlast;
		end
	end

	// Align the attacker with the target, per side
	assign d        = cfg.shift_distance;
	assign in_range = ({1'b0, d} < (DIST_W+1)'(MASK_BITS));

	always_comb begin
		if (cfg.first_is_right) begin
			hit_b   = (attack_a_s1 >> d) & body_b_s1;
			hit_a   = (attack_b_s1 << d) & body_a_s1;
			blk_b_m = (attack_a_s1 >> d) & guard_b_s1;
			blk_a_m = (guard_a_s1 >> d) & attack_b_s1;
		end else begin
			hit_a   = (attack_b_s1 >> d) & body_a_s1;
			hit_b   = (attack_a_s1 << d) & body_b_s1;
			blk_a_m = (attack_b_s1 >> d) & guard_a_s1;
			blk_b_m = (guard_b_s1 >> d) & attack_a_s1;
		end
		if (!in_range) begin
			hit_a = '0;
			hit_b = '0;
		end
	end

	// Register hit masks and reduced flags
	always_ff @(posedge clk) begin
		if (load_s2) begin
			hit_a_s2       <= hit_a;
			hit_b_s2       <= hit_b;
			flags_s2.any_a <= |hit_a;
			flags_s2.any_b <= |hit_b;
			flags_s2.blk_a <= |blk_a_m;
			flags_s2.blk_b <= |blk_b_m;
			flags_s2.last  <= last_s1;
		end
	end

endmodule

// ===== sv/smhd_latch.sv =====
// ----------------------------------------------------------------------------
// smhd_latch: window state and result register
// Latches the first overlapping row of a window, counts trailing zeros of
// the hit masks and presents one result on the window's last row.
// ----------------------------------------------------------------------------
module smhd_latch #(
	parameter int MASK_BITS = smhd_pkg::MASK_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  smhd_pkg::cfg_t                   cfg,
	input  logic                             valid_s2,
	input  logic [MASK_BITS-1:0]             hit_a_s2,
	input  logic [MASK_BITS-1:0]             hit_b_s2,
	input  smhd_pkg::row_flags_t             flags_s2,
	output logic                             go_s2,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [smhd_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import smhd_pkg::*;

	logic                 found_q;
	logic [ROW_W-1:0]     row_count_q;
	status_t              held_status_a_q, held_status_b_q;
	logic [ROW_W-1:0]     held_row_q;
	logic [ZERO_W-1:0]    held_zeros_a_q, held_zeros_b_q;

	status_t              cur_status_a, cur_status_b;
	logic [ROW_W-1:0]     cur_row;
	logic [ZERO_W-1:0]    cur_zeros_a, cur_zeros_b;
	logic [ZERO_W-1:0]    tz_a, tz_b;
	logic [ROW_SUM_W-1:0] row_rem;
	logic                 new_hit;
	logic                 out_free;
	logic                 m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// A last row needs the result register; other rows always drain
	assign out_free = !m_valid_q || m_tready;
	assign go_s2    = valid_s2 && (!flags_s2.last || out_free);

	// Trailing zero count of each hit mask
	always_comb begin
		tz_a = '0;
		tz_b = '0;
		for (int i = MASK_BITS - 1; i >= 0; i--) begin
			if (hit_a_s2[i])
				tz_a = ZERO_W'(i);
			if (hit_b_s2[i])
				tz_b = ZERO_W'(i);
		end
	end

	// Absolute row: first_row plus window index, wrapped to the sheet
	always_comb begin
		row_rem = ROW_SUM_W'(cfg.first_row) + ROW_SUM_W'(row_count_q);
		for (int k = 3; k >= 0; k--) begin
			if (int'(row_rem) >= (SHEET_ROWS << k))
				row_rem = row_rem - ROW_SUM_W'(SHEET_ROWS << k);
		end
	end

	// Merge this row into the held outcome
	assign new_hit = !found_q && (flags_s2.any_a || flags_s2.any_b);

	always_comb begin
		cur_status_a = held_status_a_q;
		cur_status_b = held_status_b_q;
		cur_zeros_a  = held_zeros_a_q;
		cur_zeros_b  = held_zeros_b_q;
		cur_row      = held_row_q;
		if (new_hit) begin
			cur_row = row_rem[ROW_W-1:0];
			if (flags_s2.any_a) begin
				cur_status_a = flags_s2.blk_a ? STAT_BLOCKED : STAT_HIT;
				cur_zeros_a  = tz_a;
			end
			if (flags_s2.any_b) begin
				cur_status_b = flags_s2.blk_b ? STAT_BLOCKED : STAT_HIT;
				cur_zeros_b  = tz_b;
			end
		end
	end

	// Window state: latch the first overlap, clear after the last row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q         <= 1'b0;
			row_count_q     <= '0;
			held_status_a_q <= STAT_NONE;
			held_status_b_q <= STAT_NONE;
			held_row_q      <= '0;
			held_zeros_a_q  <= '0;
			held_zeros_b_q  <= '0;
		end else if (go_s2) begin
			if (flags_s2.last) begin
				found_q         <= 1'b0;
				row_count_q     <= '0;
				held_status_a_q <= STAT_NONE;
				held_status_b_q <= STAT_NONE;
				held_row_q      <= '0;
				held_zeros_a_q  <= '0;
				held_zeros_b_q  <= '0;
			end else begin
				found_q         <= found_q || new_hit;
				row_count_q     <= row_count_q + ROW_W'(1);
				held_status_a_q <= cur_status_a;
				held_status_b_q <= cur_status_b;
				held_row_q      <= cur_row;
				held_zeros_a_q  <= cur_zeros_a;
				held_zeros_b_q  <= cur_zeros_b;
			end
		end
	end

	// Result register: load on the last row, hold until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (go_s2 && flags_s2.last) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2 && flags_s2.last)
			m_data_q <= {2'b00, cur_zeros_b, cur_zeros_a, cur_row,
				cur_status_b, cur_status_a};
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Window state is back to reset after a last row
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(go_s2 && flags_s2.last) |=> (!found_q && row_count_q == '0))
		else $error("window state not cleared after last row");

	// Nothing held without a latched overlap
	a_idle_holds_none: assert property (@(posedge clk) disable iff (!arst_n)
		!found_q |-> (held_status_a_q == STAT_NONE && held_status_b_q == STAT_NONE))
		else $error("outcome held without overlap");

	// A latched overlap names at least one sprite
	a_found_has_hit: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (held_status_a_q != STAT_NONE || held_status_b_q != STAT_NONE))
		else $error("overlap latched with no sprite hit");

	// A result appears only after a last row was taken
	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(go_s2 && flags_s2.last))
		else $error("result raised without a last row");

endmodule

// ===== sv/sprite_mask_hit_detector.sv =====
// ----------------------------------------------------------------------------
// sprite_mask_hit_detector: bitmask collision between two sprites
// Aligns attack masks against body and guard masks row by row, latches the
// first overlapping row and reports per-sprite hit or block on the last row.
// ----------------------------------------------------------------------------
//  Channel | Direction | Signals                         | Contents
//  --------+-----------+---------------------------------+------------------
//  s_      | in        | s_tvalid s_tready s_tdata s_tlast | one mask row
//  m_      | out       | m_tvalid m_tready m_tdata        | window result
//  cfg_    | in        | cfg_we cfg_index cfg_data        | register writes
//
//  One row is taken every cycle unless a last row waits on a stalled result;
//  rows flow through an input register, an alignment register and the result
//  register. Trailing-zero count and window update sit between the alignment
//  register and the result register.
//  A stalled result holds back only a last row and the rows behind it; other
//  rows keep flowing.
//  Reset clears the window state and sets first_is_right to 1.
// ----------------------------------------------------------------------------
module sprite_mask_hit_detector #(
	parameter int MASK_BITS = smhd_pkg::MASK_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration writes
	input  logic                             cfg_we,
	input  logic [smhd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smhd_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Row input
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// body_a[63:0] attack_a[127:64] guard_a[191:128]
	// body_b[255:192] attack_b[319:256] guard_b[383:320]
	input  logic [smhd_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             s_tlast,  // last_row
	// Result output
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// status_a[1:0] status_b[3:2] hit_row[9:4] zeros_a[15:10] zeros_b[21:16]
	output logic [smhd_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import smhd_pkg::*;

	cfg_t                 cfg;
	logic                 go_s2;
	logic                 valid_s2;
	logic [MASK_BITS-1:0] hit_a_s2, hit_b_s2;
	row_flags_t           flags_s2;

	smhd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	smhd_align #(.MASK_BITS(MASK_BITS)) u_align (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.go_s2    (go_s2),
		.valid_s2 (valid_s2),
		.hit_a_s2 (hit_a_s2),
		.hit_b_s2 (hit_b_s2),
		.flags_s2 (flags_s2)
	);

	smhd_latch #(.MASK_BITS(MASK_BITS)) u_latch (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s2 (valid_s2),
		.hit_a_s2 (hit_a_s2),
		.hit_b_s2 (hit_b_s2),
		.flags_s2 (flags_s2),
		.go_s2    (go_s2),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== dv/sprite_mask_hit_detector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_mask_hit_detector_test: self-checking bench for the hit detector
// Drives mask rows over the input stream and computes the expected window
// outcome for each last row. Every result transfer is checked field by field.
// Directed tests cover register extremes and window corner cases. Random
// windows follow, with stalls on both sides.
// ----------------------------------------------------------------------------
module sprite_mask_hit_detector_test;
	import smhd_pkg::*;

	localparam int CLK_PERIOD  = 8;
	localparam int RESET_CYCLES = 7;
	localparam int LATENCY     = 3;
	localparam int HOLD_CYCLES = 150;
	localparam int STALL_LIMIT = 1000;
	localparam int TOTAL_ROWS  = 450;
	// Index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

	typedef struct {
		logic [63:0] body_a;
		logic [63:0] attack_a;
		logic [63:0] guard_a;
		logic [63:0] body_b;
		logic [63:0] attack_b;
		logic [63:0] guard_b;
		logic        last;
	} mask_row_t;

	typedef struct packed {
		status_t          status_a;
		status_t          status_b;
		logic [ROW_W-1:0] hit_row;
		logic [ZERO_W-1:0] zeros_a;
		logic [ZERO_W-1:0] zeros_b;
	} outcome_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Local copy of the registers and the window state
	logic [DIST_W-1:0] win_shift      = '0;
	logic              win_first_right = 1'b1;
	logic [ROW_W-1:0]  win_first_row  = '0;
	logic              win_found      = 1'b0;
	logic [ROW_W-1:0]  win_rows       = '0;
	outcome_t          held           = '0;

	outcome_t outcomes_due[$];
	int       failures        = 0;
	int       rows_sent       = 0;
	int       idle_cycles     = 0;
	bit       sender_gaps     = 1'b0;
	bit       receiver_stalls = 1'b0;
	bit       hold_results    = 1'b0;

	sprite_mask_hit_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic [ZERO_W-1:0] lowest_set(logic [63:0] v);
		for (int i = 0; i < 64; i++)
			if (v[i])
				return ZERO_W'(i);
		return '0;
	endfunction

	// Update the window state for one transferred row; queue the outcome on a last row
	task automatic collide_row(input mask_row_t r);
		logic [63:0] hit_a;
		logic [63:0] hit_b;
		logic        blk_a;
		logic        blk_b;
		if (!win_found && win_shift < 7'd64) begin
			if (win_first_right) begin
				hit_b = (r.attack_a >> win_shift) & r.body_b;
				hit_a = (r.attack_b << win_shift) & r.body_a;
				blk_b = |((r.attack_a >> win_shift) & r.guard_b);
				blk_a = |((r.guard_a >> win_shift) & r.attack_b);
			end else begin
				hit_a = (r.attack_b >> win_shift) & r.body_a;
				hit_b = (r.attack_a << win_shift) & r.body_b;
				blk_a = |((r.attack_b >> win_shift) & r.guard_a);
				blk_b = |((r.guard_b >> win_shift) & r.attack_a);
			end
			if (|hit_a || |hit_b) begin
				win_found = 1'b1;
				held.hit_row = win_first_row + win_rows;
				if (|hit_a) begin
					held.status_a = blk_a ? STAT_BLOCKED : STAT_HIT;
					held.zeros_a  = lowest_set(hit_a);
				end
				if (|hit_b) begin
					held.status_b = blk_b ? STAT_BLOCKED : STAT_HIT;
					held.zeros_b  = lowest_set(hit_b);
				end
			end
		end
		win_rows = win_rows + 1'b1;
		if (r.last) begin
			outcomes_due.push_back(held);
			win_found = 1'b0;
			win_rows  = '0;
			held      = '0;
		end
	endtask

	// Offer one row, after a random gap when sender_gaps is set; return at the falling edge after the transfer
	task automatic send_row(input mask_row_t r);
		int gap;
		gap = sender_gaps ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r.guard_b, r.attack_b, r.body_b, r.guard_a, r.attack_a, r.body_a};
		s_tlast  <= r.last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		collide_row(r);
		rows_sent++;
		@(negedge clk);
	endtask

	// Stop offering rows and wait for every outstanding result plus the pipeline
	task automatic settle();
		s_tvalid <= 1'b0;
		while (outcomes_due.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		case (idx)
			REG_SHIFT_DISTANCE: win_shift       = value;
			REG_FIRST_IS_RIGHT: win_first_right = value[0];
			REG_FIRST_ROW:      win_first_row   = value[ROW_W-1:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic mask_row_t row_of(logic [63:0] ba, logic [63:0] aa, logic [63:0] ga,
			logic [63:0] bb, logic [63:0] ab, logic [63:0] gb, logic last);
		mask_row_t r;
		r.body_a   = ba;
		r.attack_a = aa;
		r.guard_a  = ga;
		r.body_b   = bb;
		r.attack_b = ab;
		r.guard_b  = gb;
		r.last     = last;
		return r;
	endfunction

	// Mix of empty, single-bit, sparse, dense and full masks
	function automatic logic [63:0] pick_mask();
		logic [63:0] m;
		case ($urandom_range(0, 7))
			0: m = '0;
			1: m = 64'd1 << $urandom_range(0, 63);
			2: m = '1;
			3: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			4: m = (64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63));
			default: m = {$urandom, $urandom};
		endcase
		return m;
	endfunction

	function automatic mask_row_t random_row(logic last);
		return row_of(pick_mask(), pick_mask(), pick_mask(),
			pick_mask(), pick_mask(), pick_mask(), last);
	endfunction

	function automatic logic [DIST_W-1:0] pick_shift();
		case ($urandom_range(0, 5))
			0: return DIST_W'($urandom_range(64, 127));
			1: return '0;
			2: return 7'd63;
			default: return DIST_W'($urandom_range(0, 63));
		endcase
	endfunction

	// Check each result transfer against the oldest outstanding outcome
	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (outcomes_due.size() == 0) begin
				$error("unexpected result transfer: tdata %h", m_tdata);
				failures++;
			end else begin
				want = outcomes_due.pop_front();
				if (m_tdata[1:0] !== want.status_a) begin
					$error("status_a: expected %0d, actual %0d", want.status_a, m_tdata[1:0]);
					failures++;
				end
				if (m_tdata[3:2] !== want.status_b) begin
					$error("status_b: expected %0d, actual %0d", want.status_b, m_tdata[3:2]);
					failures++;
				end
				if (m_tdata[9:4] !== want.hit_row) begin
					$error("hit_row: expected %0d, actual %0d", want.hit_row, m_tdata[9:4]);
					failures++;
				end
				if (m_tdata[15:10] !== want.zeros_a) begin
					$error("zeros_a: expected %0d, actual %0d", want.zeros_a, m_tdata[15:10]);
					failures++;
				end
				if (m_tdata[21:16] !== want.zeros_b) begin
					$error("zeros_b: expected %0d, actual %0d", want.zeros_b, m_tdata[21:16]);
					failures++;
				end
			end
		end
	end

	// Result receiver: random stall per result, long hold-off on request
	initial begin : result_sink
		int stall;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_results) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_results = 1'b0;
			end
			stall = receiver_stalls ? $urandom_range(0, 7) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
		end
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Reset values, plain rows and a one-sided hit
	task automatic test_reset_defaults();
		send_row(row_of('1, '1, '1, '1, '1, '1, 1'b1));
		send_row(row_of('0, '0, '0, '0, '0, '0, 1'b1));
		send_row(row_of('0, 64'd1 << 5, '0, (64'd1 << 5) | (64'd1 << 9), '0, '0, 1'b1));
		settle();
	endtask

	// Edge shifts, both directions, row wrap, unmapped index and over-wide data
	task automatic test_register_extremes();
		set_reg(REG_SHIFT_DISTANCE, 7'd63);
		set_reg(REG_FIRST_IS_RIGHT, 7'd0);
		set_reg(REG_FIRST_ROW, 7'd63);
		// both sprites hit on the second row, at opposite ends of the mask
		send_row(row_of('0, '0, '0, '0, '0, '0, 1'b0));
		send_row(row_of(64'd1, 64'd1, '0, 64'd1 << 63, 64'd1 << 63, 64'd1 << 63, 1'b0));
		send_row(row_of('0, '0, '0, '0, '0, '0, 1'b1));
		settle();
		// shifts past the mask width never overlap
		set_reg(REG_SHIFT_DISTANCE, 7'd64);
		set_reg(REG_FIRST_IS_RIGHT, 7'd1);
		send_row(row_of('1, '1, '1, '1, '1, '1, 1'b1));
		settle();
		set_reg(REG_SHIFT_DISTANCE, 7'd127);
		send_row(row_of('1, '1, '1, '1, '1, '1, 1'b1));
		settle();
		set_reg(REG_UNMAPPED, 7'h7F);
		set_reg(REG_SHIFT_DISTANCE, 7'd0);
		set_reg(REG_FIRST_IS_RIGHT, 7'h7F);
		set_reg(REG_FIRST_ROW, 7'h7F);
		send_row(row_of('1, '1, '0, '1, '1, '0, 1'b1));
		settle();
		// blocked hit on sprite a only, with sprite a on the left
		set_reg(REG_FIRST_IS_RIGHT, 7'd0);
		send_row(row_of(64'd1 << 40, '0, 64'd1 << 40, '0, 64'd1 << 40, '0, 1'b1));
		settle();
	endtask

	// Only the first overlapping row counts
	task automatic test_later_rows_ignored();
		set_reg(REG_FIRST_ROW, 7'd20);
		send_row(row_of('0, '0, '0, '0, '0, '0, 1'b0));
		send_row(row_of(64'd1 << 2, '0, '0, '0, 64'd1 << 2, '0, 1'b0));
		send_row(row_of('1, '1, '1, '1, '1, '1, 1'b0));
		send_row(row_of('1, '1, '1, '1, '1, '1, 1'b1));
		settle();
	endtask

	// Window longer than the row counter: the latched row wraps
	task automatic test_long_window();
		set_reg(REG_SHIFT_DISTANCE, 7'd0);
		set_reg(REG_FIRST_IS_RIGHT, 7'd1);
		set_reg(REG_FIRST_ROW, 7'd5);
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
		for (int i = 0; i < 70; i++) begin
			if (i == 66)
				send_row(row_of('0, 64'd1 << 17, '0, 64'd1 << 17, '0, '0, 1'b0));
			else
				send_row(row_of(pick_mask(), '0, pick_mask(), pick_mask(), '0, pick_mask(),
					i == 69));
		end
		settle();
	endtask

	// Hold the result side off while rows keep coming, then drain fully
	task automatic test_backpressure();
		set_reg(REG_SHIFT_DISTANCE, DIST_W'($urandom_range(0, 8)));
		sender_gaps = 1'b0;
		receiver_stalls = 1'b1;
		hold_results = 1'b1;
		for (int i = 0; i < 40; i++)
			send_row(random_row(i % 2 == 1));
		settle();
	endtask

	// Random windows under random register settings and idling
	task automatic test_random_windows();
		int win_len;
		while (rows_sent < TOTAL_ROWS) begin
			settle();
			sender_gaps = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;
			set_reg(REG_SHIFT_DISTANCE, pick_shift());
			if ($urandom_range(0, 1))
				set_reg(REG_FIRST_IS_RIGHT, DIST_W'($urandom_range(0, 127)));
			if ($urandom_range(0, 1))
				set_reg(REG_FIRST_ROW, DIST_W'($urandom_range(0, 127)));
			repeat ($urandom_range(2, 6)) begin
				win_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
					: $urandom_range(1, 8);
				for (int i = 0; i < win_len; i++)
					send_row(random_row(i == win_len - 1));
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_later_rows_ignored();
		test_long_window();
		test_backpressure();
		test_random_windows();

		settle();
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/smhd_pkg.sv
sv/smhd_cfg.sv
sv/smhd_align.sv
sv/smhd_latch.sv
sv/sprite_mask_hit_detector.sv
dv/sprite_mask_hit_detector_test.sv
